>>> rtl/x86enc_pkg.sv
// shared widths, sizes, command codes and opcode bytes of the x86-64 encoder
`timescale 1ns / 1ps
`default_nettype none
package x86enc_pkg;

  // sizes of the code page and the tables
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_STMTS  = 256;
  localparam int MAX_REFS   = 32;
  localparam int RESULT_CAP = 32;

  // derived widths
  localparam int ADDR_W  = $clog2(PAGE_BYTES);
  localparam int CUR_W   = $clog2(PAGE_BYTES) + 1;
  localparam int STMT_AW = $clog2(MAX_STMTS);
  localparam int REF_AW  = $clog2(MAX_REFS);
  localparam int REF_CW  = $clog2(MAX_REFS + 1);

  // payload field widths
  localparam int CMD_W   = 4;
  localparam int REG_W   = 4;
  localparam int IMM_W   = 64;
  localparam int CC_W    = 4;
  localparam int STMT_W  = 8;
  localparam int BADDR_W = 12;
  localparam int BYTE_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN   = 4'd0,
    CMD_MARK    = 4'd1,
    CMD_RET     = 4'd2,
    CMD_MOV_IMM = 4'd3,
    CMD_MOV_REG = 4'd4,
    CMD_ADD_REG = 4'd5,
    CMD_ADD_IMM = 4'd6,
    CMD_CMP_IMM = 4'd7,
    CMD_CMP_REG = 4'd8,
    CMD_JMP     = 4'd9,
    CMD_JCC     = 4'd10,
    CMD_PATCH   = 4'd11
  } cmd_e;

  // opcode and prefix bytes
  localparam logic [7:0] OP_RET     = 8'hC3;
  localparam logic [7:0] OP_MOV_IMM = 8'hB8;
  localparam logic [7:0] OP_MOV_REG = 8'h89;
  localparam logic [7:0] OP_ADD_REG = 8'h01;
  localparam logic [7:0] OP_ALU_IMM = 8'h81;
  localparam logic [7:0] OP_JMP8    = 8'hEB;
  localparam logic [7:0] OP_CMP_REG = 8'h3B;
  localparam logic [7:0] OP_JCC8    = 8'h70;
  localparam logic [7:0] MODRM_REG  = 8'hC0;
  localparam logic [7:0] MODRM_CMP  = 8'hF8;
  localparam logic [7:0] REX_W      = 8'h48;

endpackage
`default_nettype wire

>>> rtl/x86enc_cmd_if.sv
// command channel: valid/ready handshake with the command fields
`timescale 1ns / 1ps
`default_nettype none
interface x86enc_cmd_if;
  import x86enc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [REG_W-1:0]    dst_reg;
  logic [REG_W-1:0]    src_reg;
  logic [IMM_W-1:0]    immediate;
  logic [CC_W-1:0]     cond_code;
  logic [STMT_W-1:0]   target_stmt;
  logic [STMT_W-1:0]   stmt_index;

  modport source (
    output valid, command, dst_reg, src_reg, immediate, cond_code, target_stmt,
           stmt_index,
    input  ready
  );

  modport sink (
    input  valid, command, dst_reg, src_reg, immediate, cond_code, target_stmt,
           stmt_index,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/x86enc_wr_if.sv
// byte write channel: valid/ready handshake with one code page byte write
`timescale 1ns / 1ps
`default_nettype none
interface x86enc_wr_if;
  import x86enc_pkg::*;

  logic               valid;
  logic               ready;
  logic [BADDR_W-1:0] byte_addr;
  logic [BYTE_W-1:0]  byte_data;
  logic               overflow;
  logic               last;

  modport source (
    output valid, byte_addr, byte_data, overflow, last,
    input  ready
  );

  modport sink (
    input  valid, byte_addr, byte_data, overflow, last,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/x86enc_ram.sv
// generic simple dual-port ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module x86enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/x86_64_subset_encoder_with_branch_patch.sv
// top level: x86-64 subset encoder with statement table and branch patching
`timescale 1ns / 1ps
`default_nettype none
// Encodes one command per transaction into x86-64 bytes, reporting each byte written to the
// code page as one transaction on wr_o. A new command is taken once the previous one has
// finished issuing its writes; the final write may still sit in the output register. Begin
// and mark complete as they are accepted; an instruction issues one byte write per cycle
// through the output register while wr_o is not stalled, a dropped instruction one overflow
// write. A patch handles each pending reference in turn: a read of the reference memory and
// then a dependent read of the statement start memory, both with registered read data. The
// statement and reference memories are not cleared after reset, so there is no startup pass.
module x86_64_subset_encoder_with_branch_patch (
  input  logic        clk_i,
  input  logic        rst_ni,
  x86enc_cmd_if.sink  cmd_i,
  x86enc_wr_if.source wr_o
);
  import x86enc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EMIT  = 6'b000010,
    S_DROP  = 6'b000100,
    S_P_RD  = 6'b001000,
    S_P_ST  = 6'b010000,
    S_P_OUT = 6'b100000
  } state_e;

  localparam int REF_DW = ADDR_W + STMT_W;

  state_e              state_q, state_d;
  logic [CUR_W-1:0]    cursor_q, cursor_d;
  logic [REF_CW-1:0]   ref_count_q, ref_count_d;
  logic [REF_AW-1:0]   pidx_q, pidx_d;
  logic [REF_CW-1:0]   pn_q, pn_d;
  logic [3:0]          k_q, k_d;
  logic [3:0]          len_q, len_d;

  // latched command payload
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [REG_W-1:0]    rd_q, rd_d;
  logic [REG_W-1:0]    rs_q, rs_d;
  logic [IMM_W-1:0]    imm_q, imm_d;
  logic [CC_W-1:0]     cc_q, cc_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [BADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [BYTE_W-1:0]   out_data_q, out_data_d;
  logic                out_ovf_q, out_ovf_d;
  logic                out_last_q, out_last_d;

  logic                acc;
  logic                slot_free;
  logic [3:0]          ilen;
  logic                fits;
  logic                refs_full;

  logic                stmt_we;
  logic [STMT_AW-1:0]  stmt_waddr;
  logic [ADDR_W-1:0]   stmt_rdata;
  logic [STMT_AW-1:0]  stmt_raddr;
  logic                ref_we;
  logic [REF_AW-1:0]   ref_waddr;
  logic [REF_DW-1:0]   ref_wdata;
  logic [REF_DW-1:0]   ref_rdata;

  logic [STMT_W-1:0]   ref_tgt;
  logic [ADDR_W-1:0]   ref_pos;
  logic [ADDR_W-1:0]   tgt_start;
  logic [7:0]          disp;

  function automatic logic [3:0] cmd_len(input logic [CMD_W-1:0] c);
    logic [3:0] n;
    case (c)
      CMD_RET:                           n = 4'd1;
      CMD_MOV_IMM:                       n = 4'd10;
      CMD_MOV_REG, CMD_ADD_REG,
      CMD_CMP_REG:                       n = 4'd3;
      CMD_ADD_IMM, CMD_CMP_IMM:          n = 4'd7;
      CMD_JMP, CMD_JCC:                  n = 4'd2;
      default:                           n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] enc_byte(
    input logic [CMD_W-1:0] c,
    input logic [REG_W-1:0] rd,
    input logic [REG_W-1:0] rs,
    input logic [IMM_W-1:0] imm,
    input logic [CC_W-1:0]  cc,
    input logic [3:0]       k
  );
    logic [7:0] b;
    logic [2:0] i2;
    logic [2:0] i3;
    i2 = 3'(k - 4'd2);
    i3 = 3'(k - 4'd3);
    b  = 8'h00;
    case (c)
      CMD_RET: b = OP_RET;
      CMD_MOV_IMM: begin
        case (k)
          4'd0:    b = REX_W | {7'd0, rd[3]};
          4'd1:    b = OP_MOV_IMM | {5'd0, rd[2:0]};
          default: b = imm[8*i2 +: 8];
        endcase
      end
      CMD_MOV_REG, CMD_ADD_REG: begin
        case (k)
          4'd0:    b = REX_W | {5'd0, rs[3], 1'b0, rd[3]};
          4'd1:    b = (c == CMD_MOV_REG) ? OP_MOV_REG : OP_ADD_REG;
          default: b = MODRM_REG | {2'd0, rs[2:0], rd[2:0]};
        endcase
      end
      CMD_CMP_REG: begin
        case (k)
          4'd0:    b = REX_W | {5'd0, rd[3], 1'b0, rs[3]};
          4'd1:    b = OP_CMP_REG;
          default: b = MODRM_REG | {2'd0, rd[2:0], rs[2:0]};
        endcase
      end
      CMD_ADD_IMM, CMD_CMP_IMM: begin
        case (k)
          4'd0:    b = REX_W | {7'd0, rd[3]};
          4'd1:    b = OP_ALU_IMM;
          4'd2:    b = ((c == CMD_ADD_IMM) ? MODRM_REG : MODRM_CMP) | {5'd0, rd[2:0]};
          default: b = imm[8*i3 +: 8];
        endcase
      end
      CMD_JMP, CMD_JCC: begin
        if (k == 4'd0) begin
          b = (c == CMD_JMP) ? OP_JMP8 : (OP_JCC8 | {4'd0, cc});
        end else begin
          b = 8'h00;
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  x86enc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_STMTS)
  ) u_stmt_ram (
    .clk_i   (clk_i),
    .we_i    (stmt_we),
    .waddr_i (stmt_waddr),
    .wdata_i (cursor_q[ADDR_W-1:0]),
    .raddr_i (stmt_raddr),
    .rdata_o (stmt_rdata)
  );

  x86enc_ram #(
    .WIDTH (REF_DW),
    .DEPTH (MAX_REFS)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (pidx_q),
    .rdata_o (ref_rdata)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign slot_free   = !out_valid_q || wr_o.ready;

  assign ilen      = cmd_len(cmd_i.command);
  assign fits      = (32'(cursor_q) + 32'(ilen)) <= PAGE_BYTES;
  assign refs_full = 32'(ref_count_q) >= MAX_REFS;

  assign stmt_waddr = STMT_AW'(cmd_i.stmt_index);
  assign ref_waddr  = ref_count_q[REF_AW-1:0];
  // displacement byte sits right after the opcode
  assign ref_wdata  = {ADDR_W'(cursor_q + CUR_W'(1)), cmd_i.target_stmt};

  // read addresses follow the registered read data, so they hold while the output stalls
  assign ref_tgt    = ref_rdata[STMT_W-1:0];
  assign ref_pos    = ref_rdata[REF_DW-1:STMT_W];
  assign stmt_raddr = STMT_AW'(ref_tgt);
  assign tgt_start  = (32'(ref_tgt) < MAX_STMTS) ? stmt_rdata : '0;
  assign disp       = tgt_start[7:0] - ref_pos[7:0] - 8'd1;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    ref_count_d = ref_count_q;
    pidx_d      = pidx_q;
    pn_d        = pn_q;
    k_d         = k_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    rd_d        = rd_q;
    rs_d        = rs_q;
    imm_d       = imm_q;
    cc_d        = cc_q;
    out_valid_d = out_valid_q && !wr_o.ready;
    out_addr_d  = out_addr_q;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;
    stmt_we     = 1'b0;
    ref_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_d = cmd_i.command;
          rd_d  = cmd_i.dst_reg;
          rs_d  = cmd_i.src_reg;
          imm_d = cmd_i.immediate;
          cc_d  = cmd_i.cond_code;
          len_d = ilen;
          k_d   = 4'd0;
          case (cmd_i.command)
            CMD_BEGIN: begin
              cursor_d    = '0;
              ref_count_d = '0;
            end
            CMD_MARK: begin
              stmt_we = 32'(cmd_i.stmt_index) < MAX_STMTS;
            end
            CMD_RET, CMD_MOV_IMM, CMD_MOV_REG, CMD_ADD_REG, CMD_ADD_IMM,
            CMD_CMP_IMM, CMD_CMP_REG: begin
              state_d = fits ? S_EMIT : S_DROP;
            end
            CMD_JMP, CMD_JCC: begin
              if (fits && !refs_full) begin
                ref_we      = 1'b1;
                ref_count_d = ref_count_q + REF_CW'(1);
                state_d     = S_EMIT;
              end else begin
                state_d = S_DROP;
              end
            end
            CMD_PATCH: begin
              pidx_d = '0;
              pn_d   = (32'(ref_count_q) > RESULT_CAP) ? REF_CW'(RESULT_CAP) : ref_count_q;
              if (ref_count_q != '0) begin
                state_d = S_P_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = BADDR_W'(cursor_q);
          out_data_d  = enc_byte(cmd_q, rd_q, rs_q, imm_q, cc_q, k_q);
          out_ovf_d   = 1'b0;
          out_last_d  = (k_q == len_q - 4'd1);
          cursor_d    = cursor_q + CUR_W'(1);
          k_d         = k_q + 4'd1;
          if (k_q == len_q - 4'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      S_DROP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          out_data_d  = '0;
          out_ovf_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_P_RD: begin
        state_d = S_P_ST;
      end
      S_P_ST: begin
        state_d = S_P_OUT;
      end
      S_P_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = BADDR_W'(ref_pos);
          out_data_d  = disp;
          out_ovf_d   = 1'b0;
          out_last_d  = (32'(pidx_q) + 32'd1 == 32'(pn_q));
          if (32'(pidx_q) + 32'd1 == 32'(pn_q)) begin
            state_d = S_IDLE;
          end else begin
            pidx_d  = pidx_q + REF_AW'(1);
            state_d = S_P_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      ref_count_q <= '0;
      pidx_q      <= '0;
      pn_q        <= '0;
      k_q         <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      ref_count_q <= ref_count_d;
      pidx_q      <= pidx_d;
      pn_q        <= pn_d;
      k_q         <= k_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_q       <= rd_d;
    rs_q       <= rs_d;
    imm_q      <= imm_d;
    cc_q       <= cc_d;
    out_addr_q <= out_addr_d;
    out_data_q <= out_data_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign wr_o.valid     = out_valid_q;
  assign wr_o.byte_addr = out_addr_q;
  assign wr_o.byte_data = out_data_q;
  assign wr_o.overflow  = out_ovf_q;
  assign wr_o.last      = out_last_q;

  a_cursor_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) <= PAGE_BYTES)
    else $error("write cursor ran past the end of the page");

  a_refs_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ref_count_q) <= MAX_REFS)
    else $error("reference count above list size");

  a_ovf_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ovf_q) |-> (out_last_q && out_addr_q == '0 && out_data_q == '0))
    else $error("dropped command reported with a payload");

  a_patch_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_i.command == CMD_PATCH && ref_count_q != '0) |=> (state_q == S_P_RD))
    else $error("patch with pending references did not start its sweep");

endmodule
`default_nettype wire

>>> test/x86_64_subset_encoder_with_branch_patch_tb.sv
// self-checking testbench for the x86-64 subset encoder: directed and random command streams
`timescale 1ns / 1ps
module x86_64_subset_encoder_with_branch_patch_tb;
  import x86enc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_GAP       = 19;
  localparam int RANDOM_ITEMS  = 220;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_ITEMS    = 24;
  localparam int PAUSE_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int MAX_REPORTS   = 10;
  localparam int IMM_BYTES     = 10;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  rs;
    logic [IMM_W-1:0]  imm;
    logic [CC_W-1:0]   cc;
    logic [STMT_W-1:0] tgt;
    logic [STMT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [BADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  data;
    logic               ovf;
    logic               last;
  } wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  x86enc_cmd_if cmd_if ();
  x86enc_wr_if  wr_if ();

  x86_64_subset_encoder_with_branch_patch u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .wr_o  (wr_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // encoder state as seen from the command stream
  logic [CUR_W-1:0]  code_pos = '0;
  logic [CUR_W-1:0]  stmt_off [MAX_STMTS];
  bit                stmt_set [MAX_STMTS];
  logic [CUR_W-1:0]  fix_pos [MAX_REFS];
  logic [STMT_W-1:0] fix_tgt [MAX_REFS];
  int unsigned       fix_cnt = 0;
  wr_t               pending_writes [$];

  bit          src_stall = 1'b1;
  bit          sink_stall = 1'b1;
  int unsigned hold_req = 0;
  int unsigned n_cmds = 0;
  int unsigned n_writes = 0;
  int unsigned n_drops = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_cycles = 0;

  function automatic void push_drop();
    pending_writes.push_back(wr_t'{'0, '0, 1'b1, 1'b1});
  endfunction

  function automatic void emit_code(input logic [8*IMM_BYTES-1:0] enc, input int len);
    if (int'(code_pos) + len > PAGE_BYTES) begin
      push_drop();
    end else begin
      for (int k = 0; k < len; k++) begin
        pending_writes.push_back(wr_t'{code_pos[BADDR_W-1:0], enc[8*k +: 8], 1'b0,
                                       k == len - 1});
        code_pos++;
      end
    end
  endfunction

  function automatic void encode_cmd(input cmd_t c);
    logic [8*IMM_BYTES-1:0] enc;
    logic [CUR_W-1:0]       disp;
    int                     len;
    int                     n;
    enc = '0;
    len = 0;
    case (c.op)
      CMD_BEGIN: begin
        code_pos = '0;
        fix_cnt = 0;
      end
      CMD_MARK: begin
        stmt_off[c.idx] = code_pos;
        stmt_set[c.idx] = 1'b1;
      end
      CMD_RET: begin
        enc[7:0] = OP_RET;
        len = 1;
      end
      CMD_MOV_IMM: begin
        enc[7:0]   = REX_W | {7'd0, c.rd[3]};
        enc[15:8]  = OP_MOV_IMM | {5'd0, c.rd[2:0]};
        enc[79:16] = c.imm;
        len = 10;
      end
      CMD_MOV_REG, CMD_ADD_REG: begin
        enc[7:0]   = REX_W | {5'd0, c.rs[3], 1'b0, c.rd[3]};
        enc[15:8]  = (c.op == CMD_MOV_REG) ? OP_MOV_REG : OP_ADD_REG;
        enc[23:16] = MODRM_REG | {2'd0, c.rs[2:0], c.rd[2:0]};
        len = 3;
      end
      CMD_ADD_IMM, CMD_CMP_IMM: begin
        enc[7:0]   = REX_W | {7'd0, c.rd[3]};
        enc[15:8]  = OP_ALU_IMM;
        enc[23:16] = ((c.op == CMD_ADD_IMM) ? MODRM_REG : MODRM_CMP) | {5'd0, c.rd[2:0]};
        enc[55:24] = c.imm[31:0];
        len = 7;
      end
      CMD_CMP_REG: begin
        // operand order swapped: flags of dst minus src
        enc[7:0]   = REX_W | {5'd0, c.rd[3], 1'b0, c.rs[3]};
        enc[15:8]  = OP_CMP_REG;
        enc[23:16] = MODRM_REG | {2'd0, c.rd[2:0], c.rs[2:0]};
        len = 3;
      end
      CMD_JMP, CMD_JCC: begin
        if (fix_cnt >= MAX_REFS || int'(code_pos) + 2 > PAGE_BYTES) begin
          push_drop();
        end else begin
          fix_pos[fix_cnt] = code_pos + 1'b1;
          fix_tgt[fix_cnt] = c.tgt;
          fix_cnt++;
          enc[7:0] = (c.op == CMD_JMP) ? OP_JMP8 : (OP_JCC8 | {4'd0, c.cc});
          len = 2;
        end
      end
      CMD_PATCH: begin
        n = (fix_cnt > RESULT_CAP) ? RESULT_CAP : fix_cnt;
        for (int i = 0; i < n; i++) begin
          disp = stmt_off[fix_tgt[i]] - fix_pos[i] - 1'b1;
          pending_writes.push_back(wr_t'{fix_pos[i][BADDR_W-1:0], disp[7:0], 1'b0,
                                         i == n - 1});
        end
      end
      default: ;
    endcase
    if (len > 0) emit_code(enc, len);
  endfunction

  // one command transaction, optionally preceded by an idle gap
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = src_stall ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.command     <= c.op;
    cmd_if.dst_reg     <= c.rd;
    cmd_if.src_reg     <= c.rs;
    cmd_if.immediate   <= c.imm;
    cmd_if.cond_code   <= c.cc;
    cmd_if.target_stmt <= c.tgt;
    cmd_if.stmt_index  <= c.idx;
    cmd_if.valid       <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cmd_if.ready);
    encode_cmd(c);
    n_cmds++;
  endtask

  task automatic send_op(input logic [CMD_W-1:0] op, input logic [REG_W-1:0] rd,
                         input logic [REG_W-1:0] rs, input logic [IMM_W-1:0] imm,
                         input logic [CC_W-1:0] cc, input logic [STMT_W-1:0] tgt,
                         input logic [STMT_W-1:0] idx);
    send_cmd(cmd_t'{op, rd, rs, imm, cc, tgt, idx});
  endtask

  // a patch may only read statement starts that were marked
  task automatic send_patch();
    int n;
    n = (fix_cnt > RESULT_CAP) ? RESULT_CAP : fix_cnt;
    for (int i = 0; i < n; i++) begin
      if (!stmt_set[fix_tgt[i]]) send_op(CMD_MARK, '0, '0, '0, '0, '0, fix_tgt[i]);
    end
    send_op(CMD_PATCH, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic wait_drained(input int extra);
    cmd_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic cmd_t rand_instr();
    cmd_t c;
    c.op  = CMD_W'(CMD_RET + $urandom_range(0, CMD_JCC - CMD_RET));
    c.rd  = REG_W'($urandom_range(0, 15));
    c.rs  = REG_W'($urandom_range(0, 15));
    c.imm = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: c.imm = '0;
      1: c.imm = '1;
      default: ;
    endcase
    c.cc  = CC_W'($urandom_range(0, 15));
    c.tgt = STMT_W'($urandom_range(0, 255));
    c.idx = STMT_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic test_encodings();
    src_stall = 1'b1;
    sink_stall = 1'b1;
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd0);
    send_op(CMD_RET, '0, '0, '0, '0, '0, '0);
    send_op(CMD_MOV_IMM, 4'd0, 4'd15, '0, '0, '0, '0);
    send_op(CMD_MOV_IMM, 4'd15, 4'd0, '1, '1, '1, '1);
    send_op(CMD_MOV_REG, 4'd0, 4'd15, '0, '0, '0, '0);
    send_op(CMD_MOV_REG, 4'd15, 4'd0, '0, '0, '0, '0);
    send_op(CMD_ADD_REG, 4'd7, 4'd8, '1, '0, '0, '0);
    send_op(CMD_ADD_IMM, 4'd15, 4'd15, 64'hFFFF_FFFF_8000_0001, '0, '0, '0);
    send_op(CMD_CMP_IMM, 4'd8, 4'd7, 64'h1234_5678_FFFF_FFFF, '0, '0, '0);
    send_op(CMD_CMP_REG, 4'd15, 4'd7, '0, '0, '0, '0);
    send_op(CMD_CMP_REG, 4'd3, 4'd12, '0, '0, '0, '0);
    // backward branch to statement 0, forward ones to 1 and 255
    send_op(CMD_JMP, '0, '0, '0, '0, 8'd0, '0);
    send_op(CMD_JCC, '0, '0, '0, 4'd0, 8'd255, '0);
    send_op(CMD_JCC, '0, '0, '0, 4'd15, 8'd1, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd1);
    send_op(CMD_SPARE_LO, '0, '0, '0, '0, '0, '0);
    send_op(CMD_SPARE_HI, '1, '1, '1, '1, '1, '1);
    send_op(CMD_RET, '0, '0, '0, '0, '0, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd255);
    send_op(CMD_PATCH, '0, '0, '0, '0, '0, '0);
    // the reference list survives a patch
    send_op(CMD_PATCH, '0, '0, '0, '0, '0, '0);
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    send_op(CMD_PATCH, '0, '0, '0, '0, '0, '0);
    wait_drained(PAUSE_CYCLES);
  endtask

  task automatic test_ref_list_full();
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd5);
    for (int i = 0; i < MAX_REFS; i++) begin
      send_op((i % 2) ? CMD_JCC : CMD_JMP, '0, '0, '0, CC_W'($urandom_range(0, 15)),
              8'd5, '0);
    end
    send_op(CMD_JMP, '0, '0, '0, '0, 8'd5, '0);
    send_op(CMD_JCC, '0, '0, '0, 4'd9, 8'd5, '0);
    send_op(CMD_RET, '0, '0, '0, '0, '0, '0);
    send_patch();
    wait_drained(PAUSE_CYCLES);
  endtask

  // output held off while commands keep coming, so the block stalls its input
  task automatic test_output_hold();
    src_stall = 1'b0;
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < HOLD_ITEMS; i++) send_cmd(rand_instr());
    send_patch();
    wait_drained(PAUSE_CYCLES);
    src_stall = 1'b1;
  endtask

  task automatic test_page_full();
    int fills;
    src_stall = 1'b0;
    sink_stall = 1'b0;
    fills = 0;
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd7);
    // long forward branch, displacement wraps in 8 bits
    send_op(CMD_JCC, '0, '0, '0, 4'd5, 8'd8, '0);
    while (int'(code_pos) + IMM_BYTES <= PAGE_BYTES) begin
      if (fills == 200) send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd8);
      send_op(CMD_MOV_IMM, REG_W'($urandom_range(0, 15)), '0, {$urandom(), $urandom()},
              '0, '0, '0);
      fills++;
    end
    send_op(CMD_MOV_IMM, 4'd1, '0, '1, '0, '0, '0);
    send_op(CMD_ADD_IMM, 4'd2, '0, '1, '0, '0, '0);
    send_op(CMD_JMP, '0, '0, '0, '0, 8'd7, '0);
    send_op(CMD_MOV_REG, 4'd3, 4'd4, '0, '0, '0, '0);
    send_op(CMD_JCC, '0, '0, '0, 4'd2, 8'd9, '0);
    send_op(CMD_RET, '0, '0, '0, '0, '0, '0);
    send_op(CMD_JMP, '0, '0, '0, '0, 8'd7, '0);
    send_op(CMD_MARK, '0, '0, '0, '0, '0, 8'd9);
    send_patch();
    wait_drained(PAUSE_CYCLES);
    send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
    src_stall = 1'b1;
    sink_stall = 1'b1;
  endtask

  // mostly well-formed programs: statements with a few instructions each, then a patch
  task automatic test_random_programs();
    int   sent;
    int   nst;
    int   base;
    cmd_t c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_stall = ($urandom_range(0, 3) != 0);
      sink_stall = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) begin
        send_op(CMD_BEGIN, '0, '0, '0, '0, '0, '0);
        sent++;
      end
      nst = $urandom_range(1, 10);
      base = $urandom_range(0, MAX_STMTS - nst);
      for (int k = 0; k < nst; k++) begin
        send_op(CMD_MARK, '0, '0, '0, '0, '0, STMT_W'(base + k));
        sent++;
        repeat ($urandom_range(0, 3)) begin
          c = rand_instr();
          case ($urandom_range(0, 11))
            0: begin
              c.op = CMD_W'(CMD_SPARE_LO + $urandom_range(0, CMD_SPARE_HI - CMD_SPARE_LO));
              send_cmd(c);
            end
            1: begin
              c.op = CMD_MARK;
              send_cmd(c);
              sent++;
            end
            2: begin
              send_patch();
              sent++;
            end
            default: begin
              if ($urandom_range(0, 7) != 0) c.tgt = STMT_W'(base + $urandom_range(0, nst - 1));
              send_cmd(c);
              sent++;
            end
          endcase
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        send_patch();
        sent++;
      end
    end
  endtask

  // sink side: random ready gaps per transaction, plus the long hold-off on request
  initial begin : sink_ctl
    int unsigned wait_left;
    wait_left = 0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        wr_if.ready <= 1'b0;
      end else begin
        if (hold_req != 0) begin
          wait_left = hold_req;
          hold_req = 0;
        end else if (wr_if.valid && wr_if.ready) begin
          wait_left = sink_stall ? $urandom_range(0, MAX_GAP) : 0;
        end else if (wait_left != 0) begin
          wait_left--;
        end
        wr_if.ready <= (wait_left == 0);
      end
    end
  end

  always @(posedge clk) begin : check_writes
    wr_t got;
    wr_t want;
    if (rst_n && wr_if.valid && wr_if.ready) begin
      got = {wr_if.byte_addr, wr_if.byte_data, wr_if.overflow, wr_if.last};
      n_writes++;
      if (got.ovf) n_drops++;
      if (pending_writes.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected write %0d: addr %h data %h ovf %b last %b",
                   n_writes, got.addr, got.data, got.ovf, got.last);
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr || got.data !== want.data ||
            got.ovf !== want.ovf || got.last !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display({"write %0d mismatch: expected addr %h data %h ovf %b last %b, ",
                      "got addr %h data %h ovf %b last %b"},
                     n_writes, want.addr, want.data, want.ovf, want.last,
                     got.addr, got.data, got.ovf, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding",
               n_cycles, pending_writes.size());
      $display("** x86_64_subset_encoder_with_branch_patch: FAILED **");
      $finish;
    end
  end

  initial begin
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CMD_BEGIN;
    cmd_if.dst_reg     <= '0;
    cmd_if.src_reg     <= '0;
    cmd_if.immediate   <= '0;
    cmd_if.cond_code   <= '0;
    cmd_if.target_stmt <= '0;
    cmd_if.stmt_index  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encodings();
    test_ref_list_full();
    test_output_hold();
    test_page_full();
    test_random_programs();
    wait_drained(SETTLE_CYCLES);
    $display("ran %0d commands: every encoding, statement marks, branches and patches",
             n_cmds);
    $display("checked %0d byte writes, %0d of them dropped for a full page or list; %0d errors",
             n_writes, n_drops, n_mismatch);
    if (n_mismatch == 0 && pending_writes.size() == 0) begin
      $display("** x86_64_subset_encoder_with_branch_patch: PASSED **");
    end else begin
      $display("** x86_64_subset_encoder_with_branch_patch: FAILED **");
    end
    $finish;
  end

endmodule
